/* rtl/core/hrms_pkg.sv */
// Shared constants and types for the hybrid run/merge sorter.
// Used by the top level; the RAM module is generic and stands alone.
package hrms_pkg;

  localparam int CAPACITY    = 64;
  localparam int STORE_DEPTH = 64;
  localparam int RUN_LENGTH  = 16;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  // Two spare bits so that start + 2 * width never wraps.
  localparam int POS_W       = ADDR_W + 2;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam pos_t RUN_POS = POS_W'(RUN_LENGTH);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [3:0] {
    S_LOAD,
    S_RUN_START,
    S_INS_CHK,
    S_INS_HELD,
    S_INS_CMP,
    S_INS_PLACE,
    S_MRG_SETUP,
    S_MRG_LA,
    S_MRG_LB,
    S_MRG_CMP,
    S_MRG_LOAD,
    S_CPY_RD,
    S_CPY_WR,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

  // Signed greater-than on raw two's complement words.
  function automatic logic gt_signed(input word_t x, input word_t y);
    return $signed(x) > $signed(y);
  endfunction

endpackage

/* rtl/core/hybrid_run_merge_sorter.sv */
// Hybrid run/merge sorter: collects a set of signed words, sorts them in place
// in an element RAM with a scratch RAM for merges, then streams them out in order.
// Depends on hrms_pkg and hrms_ram.
//
// Usage:
//   Input channel s_*: one signed 32-bit value per transfer, s_tlast closes the
//   set. Up to CAPACITY values are kept; later ones are dropped and the set is
//   flagged as truncated. Input transfers are accepted back to back; s_tready is high
//   only while the block collects a set.
//   After the closing transfer the block insertion-sorts runs of RUN_LENGTH
//   entries, then merges runs bottom-up, each pass merging into scratch and
//   copying back, all bounded by the single read port of each RAM.
//   Output channel m_*: one sorted value per transfer, m_tlast on the last one
//   and m_tuser set on every value of a truncated set. The next entry is read
//   only once the output register is free or being drained; a stalled receiver
//   holds the output register and the read of the next entry waits for it.
//   The next set is accepted as soon as the last result sits in the output register.
//   Reset clears the fill count, the truncation flag and the output valid; RAM
//   contents are not cleared and need not be.
module hybrid_run_merge_sorter
  import hrms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast,
  output logic        m_tuser    // [0] truncated
);

  state_t state, state_next;

  logic [CNT_W-1:0] count, count_next;
  logic             overflow, overflow_next;
  pos_t lo, lo_next, hi, hi_next, i, i_next, pos, pos_next;
  pos_t k, k_next, a, a_next, b, b_next, mid, mid_next;
  pos_t start, start_next, width, width_next;
  word_t held, held_next, va, va_next, vb, vb_next;
  logic  took_b, took_b_next;

  // Element store port signals.
  logic              st_we;
  logic [ADDR_W-1:0] st_waddr, st_raddr;
  word_t             st_wdata, st_rdata;
  // Merge scratch port signals.
  logic              sc_we;
  logic [ADDR_W-1:0] sc_waddr, sc_raddr;
  word_t             sc_wdata, sc_rdata;

  logic out_load;

  hrms_ram #(.DEPTH(STORE_DEPTH), .WIDTH(DATA_W)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  hrms_ram #(.DEPTH(STORE_DEPTH), .WIDTH(DATA_W)) u_scratch (
    .clk   (clk),
    .we    (sc_we),
    .waddr (sc_waddr),
    .wdata (sc_wdata),
    .raddr (sc_raddr),
    .rdata (sc_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    lo     <= lo_next;
    hi     <= hi_next;
    i      <= i_next;
    pos    <= pos_next;
    k      <= k_next;
    a      <= a_next;
    b      <= b_next;
    mid    <= mid_next;
    start  <= start_next;
    width  <= width_next;
    held   <= held_next;
    va     <= va_next;
    vb     <= vb_next;
    took_b <= took_b_next;
  end

  always_comb begin
    pos_t n;
    pos_t run_end;
    pos_t seg_mid;
    pos_t seg_end;
    logic a_ok;
    logic b_ok;
    logic take_b;

    n       = POS_W'(count);
    run_end = lo + RUN_POS - 1'b1;
    seg_mid = start + width - 1'b1;
    seg_end = start + (width << 1) - 1'b1;
    a_ok    = (a <= mid);
    b_ok    = (b <= hi);
    take_b  = b_ok && (!a_ok || gt_signed(va, vb));

    state_next    = state;
    count_next    = count;
    overflow_next = overflow;
    lo_next       = lo;
    hi_next       = hi;
    i_next        = i;
    pos_next      = pos;
    k_next        = k;
    a_next        = a;
    b_next        = b;
    mid_next      = mid;
    start_next    = start;
    width_next    = width;
    held_next     = held;
    va_next       = va;
    vb_next       = vb;
    took_b_next   = took_b;

    s_tready = 1'b0;
    st_we    = 1'b0;
    st_waddr = '0;
    st_wdata = held;
    st_raddr = '0;
    sc_we    = 1'b0;
    sc_waddr = k[ADDR_W-1:0];
    sc_wdata = va;
    sc_raddr = k[ADDR_W-1:0];
    out_load = 1'b0;

    unique case (state)
      S_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (count < CAP_CNT) begin
            st_we      = 1'b1;
            st_waddr   = count[ADDR_W-1:0];
            st_wdata   = s_tdata;
            count_next = count + 1'b1;
          end else begin
            overflow_next = 1'b1;
          end
          if (s_tlast) begin
            lo_next    = '0;
            state_next = S_RUN_START;
          end
        end
      end

      S_RUN_START: begin
        hi_next    = (run_end > n - 1'b1) ? n - 1'b1 : run_end;
        i_next     = lo + 1'b1;
        state_next = S_INS_CHK;
      end

      S_INS_CHK: begin
        if (i > hi) begin
          lo_next = lo + RUN_POS;
          if (lo + RUN_POS >= n) begin
            width_next = RUN_POS;
            start_next = '0;
            state_next = S_MRG_SETUP;
          end else begin
            state_next = S_RUN_START;
          end
        end else begin
          st_raddr   = i[ADDR_W-1:0];
          state_next = S_INS_HELD;
        end
      end

      S_INS_HELD: begin
        held_next  = st_rdata;
        pos_next   = i;
        st_raddr   = i[ADDR_W-1:0] - 1'b1;
        state_next = S_INS_CMP;
      end

      S_INS_CMP: begin
        // Read data holds the entry just left of pos.
        st_we    = 1'b1;
        st_waddr = pos[ADDR_W-1:0];
        if (gt_signed(st_rdata, held)) begin
          st_wdata = st_rdata;
          pos_next = pos - 1'b1;
          if (pos - 1'b1 > lo) begin
            st_raddr = pos[ADDR_W-1:0] - 2'd2;
          end else begin
            state_next = S_INS_PLACE;
          end
        end else begin
          st_wdata   = held;
          i_next     = i + 1'b1;
          state_next = S_INS_CHK;
        end
      end

      S_INS_PLACE: begin
        st_we      = 1'b1;
        st_waddr   = pos[ADDR_W-1:0];
        st_wdata   = held;
        i_next     = i + 1'b1;
        state_next = S_INS_CHK;
      end

      S_MRG_SETUP: begin
        if (width >= n) begin
          k_next     = '0;
          state_next = S_OUT_RD;
        end else if (start >= n) begin
          width_next = width << 1;
          start_next = '0;
        end else begin
          mid_next = seg_mid;
          hi_next  = (seg_end > n - 1'b1) ? n - 1'b1 : seg_end;
          if (seg_mid < ((seg_end > n - 1'b1) ? n - 1'b1 : seg_end)) begin
            a_next     = start;
            b_next     = seg_mid + 1'b1;
            k_next     = start;
            st_raddr   = start[ADDR_W-1:0];
            state_next = S_MRG_LA;
          end else begin
            start_next = start + (width << 1);
          end
        end
      end

      S_MRG_LA: begin
        va_next    = st_rdata;
        st_raddr   = b[ADDR_W-1:0];
        state_next = S_MRG_LB;
      end

      S_MRG_LB: begin
        vb_next    = st_rdata;
        state_next = S_MRG_CMP;
      end

      S_MRG_CMP: begin
        if (!a_ok && !b_ok) begin
          k_next     = start;
          state_next = S_CPY_RD;
        end else begin
          // Ties take the left run, which keeps the merge stable.
          sc_we       = 1'b1;
          sc_wdata    = take_b ? vb : va;
          k_next      = k + 1'b1;
          took_b_next = take_b;
          if (take_b) begin
            b_next   = b + 1'b1;
            st_raddr = b[ADDR_W-1:0] + 1'b1;
          end else begin
            a_next   = a + 1'b1;
            st_raddr = a[ADDR_W-1:0] + 1'b1;
          end
          state_next = S_MRG_LOAD;
        end
      end

      S_MRG_LOAD: begin
        if (took_b) begin
          vb_next = st_rdata;
        end else begin
          va_next = st_rdata;
        end
        state_next = S_MRG_CMP;
      end

      S_CPY_RD: begin
        sc_raddr   = k[ADDR_W-1:0];
        state_next = S_CPY_WR;
      end

      S_CPY_WR: begin
        st_we    = 1'b1;
        st_waddr = k[ADDR_W-1:0];
        st_wdata = sc_rdata;
        if (k == hi) begin
          start_next = start + (width << 1);
          state_next = S_MRG_SETUP;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_CPY_RD;
        end
      end

      S_OUT_RD: begin
        // Fetch only when the output register is free by the next edge.
        if (!m_tvalid || m_tready) begin
          st_raddr   = k[ADDR_W-1:0];
          state_next = S_OUT_LD;
        end
      end

      S_OUT_LD: begin
        out_load = 1'b1;
        if (k == n - 1'b1) begin
          count_next    = '0;
          overflow_next = 1'b0;
          state_next    = S_LOAD;
        end else begin
          k_next     = k + 1'b1;
          state_next = S_OUT_RD;
        end
      end

      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Output register: it is always empty or being drained when a load arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= st_rdata;
      m_tlast <= (k == POS_W'(count) - 1'b1);
      m_tuser <= overflow;
    end
  end

endmodule

/* rtl/core/hrms_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module hrms_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
